@@ rtl/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg
// Types, constants and the microcode program of the text compaction
// codeword encoder.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Capacity and field widths
  localparam int MAX_DATA_CW = 1024;
  localparam int CNT_W       = $clog2(MAX_DATA_CW + 1);
  localparam int CW_W        = 11;
  localparam int POS_W       = 11;
  localparam int VAL_W       = 5;
  localparam int RW_W        = 6;
  localparam int EC_W        = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;

  // Total length (descriptor + data + check slots) and its divider
  localparam int NEED_W = 11;
  localparam int K_W    = 10;
  localparam int DCNT_W = $clog2(NEED_W);

  // Coded values
  localparam logic [VAL_W-1:0] VAL_TO_LOWER = 5'd27;
  localparam logic [VAL_W-1:0] VAL_SHIFT    = 5'd28;
  localparam logic [VAL_W-1:0] VAL_PAD      = 5'd29;
  localparam logic [CW_W-1:0]  CW_PAD       = 11'd900;
  localparam logic [CW_W-1:0]  CW_RADIX     = 11'd30;
  localparam logic [RW_W-1:0]  RW_MAX       = 6'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EC_LEVEL  = 1'b1;

  typedef enum logic [1:0] {
    MODE_UPPER = 2'd0,
    MODE_LOWER = 2'd1,
    MODE_DIGIT = 2'd2,
    MODE_OTHER = 2'd3
  } mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [CW_W-1:0]  codeword;
    logic [POS_W-1:0] position;
    logic             overflow;
    logic             end_of_run;
  } out_t;

  // Microcode
  localparam int STEP_W = 4;

  typedef enum logic [3:0] {
    UOP_IDLE,
    UOP_SW1,
    UOP_SW2,
    UOP_VAL,
    UOP_FLUSH,
    UOP_DINIT,
    UOP_DIV,
    UOP_PADSET,
    UOP_PAD,
    UOP_DESC
  } uop_e;

  typedef enum logic [2:0] {
    CND_SEQ,
    CND_GOTO,
    CND_NOSW2,
    CND_NOTLAST,
    CND_DIVMORE,
    CND_PADMORE
  } ucond_e;

  typedef struct packed {
    uop_e              op;
    ucond_e            cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic no_sw2;
    logic not_last;
    logic div_more;
    logic pad_more;
  } flags_t;

  localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] ST_VAL    = 4'd3;
  localparam logic [STEP_W-1:0] ST_DIV    = 4'd6;
  localparam logic [STEP_W-1:0] ST_PAD    = 4'd8;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      4'd0:    w = '{op: UOP_IDLE,   cond: CND_SEQ,     target: ST_IDLE};
      4'd1:    w = '{op: UOP_SW1,    cond: CND_NOSW2,   target: ST_VAL};
      4'd2:    w = '{op: UOP_SW2,    cond: CND_SEQ,     target: ST_IDLE};
      4'd3:    w = '{op: UOP_VAL,    cond: CND_NOTLAST, target: ST_IDLE};
      4'd4:    w = '{op: UOP_FLUSH,  cond: CND_SEQ,     target: ST_IDLE};
      4'd5:    w = '{op: UOP_DINIT,  cond: CND_SEQ,     target: ST_IDLE};
      4'd6:    w = '{op: UOP_DIV,    cond: CND_DIVMORE, target: ST_DIV};
      4'd7:    w = '{op: UOP_PADSET, cond: CND_SEQ,     target: ST_IDLE};
      4'd8:    w = '{op: UOP_PAD,    cond: CND_PADMORE, target: ST_PAD};
      4'd9:    w = '{op: UOP_DESC,   cond: CND_GOTO,    target: ST_IDLE};
      default: w = '{op: UOP_IDLE,   cond: CND_GOTO,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/tcce_seq.sv @@
// ----------------------------------------------------------------------------
// tcce_seq
// Step counter and microcode ROM: advances one step when the datapath lets
// it go, taking the jump of the current control word when its condition holds.
// ----------------------------------------------------------------------------
module tcce_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  tcce_pkg::flags_t flags_i,
  output tcce_pkg::uword_t uword_o
);
  import tcce_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  uword_t            uw;
  logic              take;

  assign uw      = ucode_rom(step_q);
  assign uword_o = uw;

  always_comb begin
    unique case (uw.cond)
      CND_SEQ:     take = 1'b0;
      CND_GOTO:    take = 1'b1;
      CND_NOSW2:   take = flags_i.no_sw2;
      CND_NOTLAST: take = flags_i.not_last;
      CND_DIVMORE: take = flags_i.div_more;
      CND_PADMORE: take = flags_i.pad_more;
      default:     take = 1'b1;
    endcase
    step_d = step_q;
    if (go_i) begin
      step_d = take ? uw.target : step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

@@ rtl/text_compaction_codeword_encoder_top.sv @@
// ----------------------------------------------------------------------------
// text_compaction_codeword_encoder_top
// Text compaction encoder: characters to 5-bit values with mode switches,
// value pairs to codewords, row padding and a closing length descriptor.
// ----------------------------------------------------------------------------
//  channel  | handshake              | word
//  ---------+------------------------+------------------------------------
//  in       | in_valid_i/in_ready_o  | in_t: char_code, last_char
//  out      | out_valid_o/out_ready_i| out_t: codeword, position, ...
//  cfg      | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// A character runs through the steps accept, first switch (idle when none),
// second switch (only with two switch values) and character value. The last
// character adds a flush, a divider load, 11 remainder steps, a pad setup,
// one step per 900 pad plus one to leave the loop, and the descriptor.
// Switch, value, flush, pad and descriptor steps stall while the output word
// is held and not taken. Reset clears all state; row_width 3, ec_level -1.
// ----------------------------------------------------------------------------
module text_compaction_codeword_encoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tcce_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tcce_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import tcce_pkg::*;

  // Configuration
  logic [RW_W-1:0]        row_width_q;
  logic signed [EC_W-1:0] ec_level_q;

  // String state
  mode_e            mode_q;
  logic [VAL_W-1:0] pend_val_q;
  logic             pend_vld_q;
  logic [CNT_W-1:0] count_q;
  logic             ovf_q;

  // Latched item
  mode_e            tmode_q;
  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] sw1_q;
  logic [1:0]       nsw_q;
  logic             last_q;

  // Divider and padding
  logic [NEED_W-1:0] dvd_q;
  logic [RW_W-1:0]   rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [RW_W-1:0]   pad_cnt_q;
  logic [POS_W-1:0]  len_q;

  // Output register
  logic out_valid_q;
  out_t out_q;

  uword_t uw;
  flags_t flags;
  logic   go, slot_free, needs_slot;

  tcce_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .flags_i (flags),
    .uword_o (uw)
  );

  assign in_ready_o  = (uw.op == UOP_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (uw.op)
      UOP_SW1, UOP_SW2, UOP_VAL, UOP_FLUSH, UOP_PAD, UOP_DESC: needs_slot = 1'b1;
      default:                                                 needs_slot = 1'b0;
    endcase
  end

  assign go = (uw.op == UOP_IDLE) ? in_valid_i : (!needs_slot || slot_free);

  assign flags = '{no_sw2:   (nsw_q != 2'd2),
                   not_last: !last_q,
                   div_more: (dcnt_q != '0),
                   pad_more: (pad_cnt_q != '0)};

  // Classify the incoming character
  mode_e            in_mode;
  logic [VAL_W-1:0] in_val;
  logic [1:0]       in_nsw;
  logic [7:0]       ch;

  assign ch = in_data_i.char_code;

  always_comb begin
    if (ch >= 8'h30 && ch <= 8'h39) begin
      in_mode = MODE_DIGIT;
      in_val  = VAL_W'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h5a) begin
      in_mode = MODE_UPPER;
      in_val  = VAL_W'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      in_mode = MODE_LOWER;
      in_val  = VAL_W'(ch - 8'h61);
    end else begin
      in_mode = MODE_OTHER;
      in_val  = '0;
    end
    if (mode_q == MODE_OTHER || in_mode == MODE_OTHER || in_mode == mode_q) begin
      in_nsw = 2'd0;
    end else if (mode_q == MODE_LOWER && in_mode == MODE_UPPER) begin
      in_nsw = 2'd2;
    end else begin
      in_nsw = 2'd1;
    end
  end

  // Effective row width and check slot count
  logic [RW_W-1:0] w_eff;
  logic [3:0]      k_exp;
  logic [K_W-1:0]  k_slots;

  always_comb begin
    if (row_width_q == '0) begin
      w_eff = RW_W'(1);
    end else if (row_width_q > RW_MAX) begin
      w_eff = RW_MAX;
    end else begin
      w_eff = row_width_q;
    end
    if (ec_level_q < 5'sd0) begin
      k_exp = 4'd0;
    end else if (ec_level_q > 5'sd8) begin
      k_exp = 4'd9;
    end else begin
      k_exp = 4'(ec_level_q[3:0]) + 4'd1;
    end
    k_slots = (k_exp == 4'd0) ? '0 : (K_W'(1) << k_exp);
  end

  // Value to push this step
  logic             push_en;
  logic [VAL_W-1:0] push_val;

  always_comb begin
    push_en  = 1'b0;
    push_val = '0;
    case (uw.op)
      UOP_SW1: begin
        push_en  = (nsw_q != 2'd0);
        push_val = sw1_q;
      end
      UOP_SW2: begin
        push_en  = (nsw_q == 2'd2);
        push_val = VAL_SHIFT;
      end
      UOP_VAL: begin
        push_en  = 1'b1;
        push_val = val_q;
      end
      UOP_FLUSH: begin
        push_en  = pend_vld_q;
        push_val = VAL_PAD;
      end
      default: begin
        push_en  = 1'b0;
        push_val = '0;
      end
    endcase
  end

  logic [CW_W-1:0]   pair_cw;
  logic [CNT_W-1:0]  count_inc;
  logic              room;
  logic [RW_W:0]     trial;
  logic [NEED_W-1:0] need;
  logic              emit;

  assign pair_cw   = CW_W'(pend_val_q) * CW_RADIX + CW_W'(push_val);
  assign count_inc = count_q + CNT_W'(1);
  assign room      = (count_q < CNT_W'(MAX_DATA_CW));
  assign trial     = {rem_q, dvd_q[NEED_W-1]};
  assign need      = NEED_W'(count_q) + NEED_W'(1) + NEED_W'(k_slots);

  // a word is loaded into the output register this cycle
  assign emit = go && ((push_en && pend_vld_q && room) ||
                       (uw.op == UOP_PAD && pad_cnt_q != '0) ||
                       (uw.op == UOP_DESC));

  // Datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= 6'd3;
      ec_level_q  <= -5'sd1;
      mode_q      <= MODE_UPPER;
      pend_val_q  <= '0;
      pend_vld_q  <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      tmode_q     <= MODE_UPPER;
      val_q       <= '0;
      sw1_q       <= '0;
      nsw_q       <= '0;
      last_q      <= 1'b0;
      dvd_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      pad_cnt_q   <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ROW_WIDTH: row_width_q <= cfg_wdata_i[RW_W-1:0];
          REG_EC_LEVEL:  ec_level_q  <= $signed(cfg_wdata_i[EC_W-1:0]);
          default:       ;
        endcase
      end

      // drop the output word once taken, unless a new one is loaded
      if (out_valid_q && out_ready_i && !emit) begin
        out_valid_q <= 1'b0;
      end

      if (go) begin
        unique case (uw.op)
          UOP_IDLE: begin
            tmode_q <= in_mode;
            val_q   <= in_val;
            nsw_q   <= in_nsw;
            sw1_q   <= (in_mode == MODE_LOWER) ? VAL_TO_LOWER : VAL_SHIFT;
            last_q  <= in_data_i.last_char;
          end
          UOP_DINIT: begin
            dvd_q  <= need;
            rem_q  <= '0;
            dcnt_q <= DCNT_W'(NEED_W - 1);
          end
          UOP_DIV: begin
            // one restoring division bit per step
            if (trial >= {1'b0, w_eff}) begin
              rem_q <= RW_W'(trial - {1'b0, w_eff});
            end else begin
              rem_q <= trial[RW_W-1:0];
            end
            dvd_q <= {dvd_q[NEED_W-2:0], 1'b0};
            if (dcnt_q != '0) begin
              dcnt_q <= dcnt_q - DCNT_W'(1);
            end
          end
          UOP_PADSET: begin
            pad_cnt_q <= (rem_q == '0) ? '0 : w_eff - rem_q;
            len_q     <= POS_W'(count_q) + POS_W'(1);
          end
          UOP_PAD: begin
            if (pad_cnt_q != '0) begin
              out_valid_q         <= 1'b1;
              out_q.codeword      <= CW_PAD;
              out_q.position      <= len_q;
              out_q.overflow      <= ovf_q;
              out_q.end_of_run    <= 1'b0;
              len_q               <= len_q + POS_W'(1);
              pad_cnt_q           <= pad_cnt_q - RW_W'(1);
            end
          end
          UOP_DESC: begin
            out_valid_q      <= 1'b1;
            out_q.codeword   <= CW_W'(len_q);
            out_q.position   <= '0;
            out_q.overflow   <= ovf_q;
            out_q.end_of_run <= 1'b1;
            // return to the start-of-string state
            mode_q     <= MODE_UPPER;
            pend_val_q <= '0;
            pend_vld_q <= 1'b0;
            count_q    <= '0;
            ovf_q      <= 1'b0;
          end
          default: begin
          end
        endcase

        if (uw.op == UOP_VAL) begin
          mode_q <= tmode_q;
        end

        if (push_en) begin
          if (!pend_vld_q) begin
            pend_val_q <= push_val;
            pend_vld_q <= 1'b1;
          end else begin
            pend_vld_q <= 1'b0;
            pend_val_q <= '0;
            if (room) begin
              count_q          <= count_inc;
              out_valid_q      <= 1'b1;
              out_q.codeword   <= pair_cw;
              out_q.position   <= POS_W'(count_inc);
              out_q.overflow   <= ovf_q;
              out_q.end_of_run <= 1'b0;
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
      end
    end
  end

endmodule
